// File: rtl/cbez_pkg.sv
`timescale 1ns / 1ps
// Shared constants and register codes for the cubic Bezier point evaluator.
package cbez_pkg;

	localparam int COORD_BITS_DEF  = 16;
	localparam int T_FRAC_BITS_DEF = 16;

	localparam int NUM_REGS     = 8;
	localparam int REG_IDX_BITS = $clog2(NUM_REGS);

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_P0_X = 3'd0,
		REG_P1_X = 3'd1,
		REG_P2_X = 3'd2,
		REG_P3_X = 3'd3,
		REG_P0_Y = 3'd4,
		REG_P1_Y = 3'd5,
		REG_P2_Y = 3'd6,
		REG_P3_Y = 3'd7
	} reg_idx_t;

	// reset values, cut to the coordinate width on use
	localparam logic [31:0] REG_RST [NUM_REGS] = '{
		32'd0, 32'd100, 32'd150, 32'd200, 32'd100, 32'd80, 32'd150, 32'd155
	};

endpackage

// File: rtl/cbez_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: curve parameter in, curve point out.
interface cbez_t_if #(
	parameter int T_FRAC_BITS = cbez_pkg::T_FRAC_BITS_DEF
) ();
	logic                   valid;
	logic                   ready;
	logic [T_FRAC_BITS-1:0] param_t;

	modport source (output valid, output param_t, input ready);
	modport sink (input valid, input param_t, output ready);
endinterface

interface cbez_pt_if #(
	parameter int COORD_BITS = cbez_pkg::COORD_BITS_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink (input valid, input point_x, input point_y, output ready);
endinterface

// File: rtl/cubic_bezier_point_eval_core.sv
`timescale 1ns / 1ps
// Cubic Bezier point evaluator by de Casteljau's construction, six-stage pipeline.
// Takes one curve parameter t (unsigned fraction) per clock unless stalled, and returns the curve
// point at t for the four control points held in the configuration registers.
// From an accepted t to the point on out_ch, each of the three lerp levels is
// one multiply stage ((n2-n1)*t) and one add/truncate stage.
// Throughput is one point per cycle; a stall on out_ch backs up stage by stage,
// and empty stages keep filling, so in_ch only stalls when all six are full.
// Every lerp is trunc(n1 + (n2-n1)*t), rounded toward zero. Write the control
// points only while the pipeline is empty.
module cubic_bezier_point_eval_core #(
	parameter int COORD_BITS  = cbez_pkg::COORD_BITS_DEF,
	parameter int T_FRAC_BITS = cbez_pkg::T_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cbez_pkg::REG_IDX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]             cfg_data,
	cbez_t_if.sink                            in_ch,
	cbez_pt_if.source                         out_ch
);
	import cbez_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int TW = T_FRAC_BITS;
	localparam int PW = CW + TW + 2;

	function automatic logic signed [PW-1:0] mul_diff(
		input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b,
		input logic [TW-1:0]        t
	);
		logic signed [CW:0] d;
		logic signed [TW:0] ts;
		d  = (CW+1)'(b) - (CW+1)'(a);
		ts = $signed({1'b0, t});
		return PW'(d) * PW'(ts);
	endfunction

	function automatic logic signed [CW-1:0] lerp_fin(
		input logic signed [CW-1:0] a,
		input logic signed [PW-1:0] p
	);
		logic signed [PW-1:0] num;
		logic signed [PW-1:0] q;
		num = (PW'(a) <<< TW) + p;
		q   = num >>> TW;
		if (num[PW-1] && (num[TW-1:0] != '0)) begin
			q = q + PW'(1);
		end
		return q[CW-1:0];
	endfunction

	// control point registers
	logic [CW-1:0] cfg_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= REG_RST[i][CW-1:0];
			end
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	logic signed [CW-1:0] cp [2][4];

	always_comb begin
		cp[0][0] = cfg_q[REG_P0_X];
		cp[0][1] = cfg_q[REG_P1_X];
		cp[0][2] = cfg_q[REG_P2_X];
		cp[0][3] = cfg_q[REG_P3_X];
		cp[1][0] = cfg_q[REG_P0_Y];
		cp[1][1] = cfg_q[REG_P1_Y];
		cp[1][2] = cfg_q[REG_P2_Y];
		cp[1][3] = cfg_q[REG_P3_Y];
	end

	// stage valids and per-stage advance
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	assign adv6 = !vld_s6 || out_ch.ready;
	assign adv5 = !vld_s5 || adv6;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;

	assign in_ch.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_ch.valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
		end
	end

	// datapath
	logic [TW-1:0]        t_s1, t_s2, t_s3, t_s4, t_s5;
	logic signed [PW-1:0] prod_s1 [2][3];
	logic signed [CW-1:0] base_s1 [2][3];
	logic signed [CW-1:0] lv1_s2  [2][3];
	logic signed [PW-1:0] prod_s3 [2][2];
	logic signed [CW-1:0] base_s3 [2][2];
	logic signed [CW-1:0] lv2_s4  [2][2];
	logic signed [PW-1:0] prod_s5 [2];
	logic signed [CW-1:0] base_s5 [2];
	logic signed [CW-1:0] pt_s6   [2];

	always_ff @(posedge clk) begin
		if (adv1 && in_ch.valid) begin
			t_s1 <= in_ch.param_t;
			for (int ax = 0; ax < 2; ax++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s1[ax][k] <= mul_diff(cp[ax][k], cp[ax][k+1], in_ch.param_t);
					base_s1[ax][k] <= cp[ax][k];
				end
			end
		end
		if (adv2 && vld_s1) begin
			t_s2 <= t_s1;
			for (int ax = 0; ax < 2; ax++) begin
				for (int k = 0; k < 3; k++) begin
					lv1_s2[ax][k] <= lerp_fin(base_s1[ax][k], prod_s1[ax][k]);
				end
			end
		end
		if (adv3 && vld_s2) begin
			t_s3 <= t_s2;
			for (int ax = 0; ax < 2; ax++) begin
				for (int k = 0; k < 2; k++) begin
					prod_s3[ax][k] <= mul_diff(lv1_s2[ax][k], lv1_s2[ax][k+1], t_s2);
					base_s3[ax][k] <= lv1_s2[ax][k];
				end
			end
		end
		if (adv4 && vld_s3) begin
			t_s4 <= t_s3;
			for (int ax = 0; ax < 2; ax++) begin
				for (int k = 0; k < 2; k++) begin
					lv2_s4[ax][k] <= lerp_fin(base_s3[ax][k], prod_s3[ax][k]);
				end
			end
		end
		if (adv5 && vld_s4) begin
			t_s5 <= t_s4;
			for (int ax = 0; ax < 2; ax++) begin
				prod_s5[ax] <= mul_diff(lv2_s4[ax][0], lv2_s4[ax][1], t_s4);
				base_s5[ax] <= lv2_s4[ax][0];
			end
		end
		if (adv6 && vld_s5) begin
			for (int ax = 0; ax < 2; ax++) begin
				pt_s6[ax] <= lerp_fin(base_s5[ax], prod_s5[ax]);
			end
		end
	end

	assign out_ch.valid   = vld_s6;
	assign out_ch.point_x = pt_s6[0];
	assign out_ch.point_y = pt_s6[1];

	// input stalls only with every stage full and the output blocked
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6
			&& !out_ch.ready))
		else $error("input stalled with a free stage");

	// zero parameter gives zero first-level products
	a_zero_t_prod: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && t_s1 == '0) |-> (prod_s1[0][0] == '0 && prod_s1[1][2] == '0))
		else $error("nonzero product at zero parameter");

	// zero parameter in the last level returns its first operand
	a_zero_t_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv6 && vld_s5 && t_s5 == '0) |=>
			(pt_s6[0] == $past(base_s5[0]) && pt_s6[1] == $past(base_s5[1])))
		else $error("last lerp at zero parameter differs from its start operand");

endmodule
